@@ src/x86_modrm_sib_address_decode_core_assert.svh @@
// Assertion macros used by the checker of the address decode core.
`ifndef X86_MODRM_SIB_ADDRESS_DECODE_CORE_ASSERT_SVH
`define X86_MODRM_SIB_ADDRESS_DECODE_CORE_ASSERT_SVH

// Clocked assertion with reset disable.
`define X86EA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A stalled transfer keeps valid high and its payload steady.
`define X86EA_ASSERT_HOLD(label, clk, rst_n, vld, rdy, data, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && !rdy) |=> (vld && $stable(data))) else $error(msg);

`endif

@@ src/x86ea_pkg.sv @@
package x86ea_pkg;

  localparam logic [4:0] NoReg   = 5'd16;
  localparam logic [2:0] SegSs   = 3'd2;
  localparam logic [2:0] SegDs   = 3'd3;
  localparam logic [2:0] SegNone = 3'd6;
  localparam logic [2:0] SegLastOverride = 3'd5;

  localparam logic [1:0] AddrSize16 = 2'd0;

  localparam logic [1:0] ModNoDisp  = 2'd0;
  localparam logic [1:0] ModDisp8   = 2'd1;

  localparam logic [2:0] RmSib      = 3'd4;
  localparam logic [2:0] RmDirect16 = 3'd6;
  localparam logic [2:0] BaseDisp32 = 3'd5;
  localparam logic [3:0] IndexNone  = 4'd4;
  localparam logic [4:0] RegEsp     = 5'd4;
  localparam logic [4:0] RegEbp     = 5'd5;

  typedef struct packed {
    logic [7:0]  modrm_byte;
    logic [7:0]  sib_byte;
    logic [31:0] disp_raw;
    logic [1:0]  addr_size;
    logic        rex_x_bit;
    logic        rex_b_bit;
    logic        long_mode;
    logic [2:0]  seg_override;
    logic        add_seg_base;
    logic [3:0]  esp_pop_adjust;
    logic [63:0] disp_address;
    logic [2:0]  rip_extra;
  } req_t;

  typedef struct packed {
    logic [4:0]  base_reg;
    logic [4:0]  index_reg;
    logic [1:0]  scale_shift;
    logic [63:0] displacement;
    logic [2:0]  segment_used;
    logic        wrap_16;
    logic [2:0]  extra_bytes;
  } rsp_t;

  // 16-bit register-pair table: base part
  function automatic logic [4:0] base16(input logic [2:0] rm);
    logic [4:0] r;
    case (rm)
      3'd0, 3'd1, 3'd7:       r = 5'd3;
      3'd2, 3'd3, 3'd6:       r = 5'd5;
      3'd4:                   r = 5'd6;
      default:                r = 5'd7;
    endcase
    return r;
  endfunction

  // 16-bit register-pair table: index part
  function automatic logic [4:0] index16(input logic [2:0] rm);
    logic [4:0] r;
    case (rm)
      3'd0, 3'd2: r = 5'd6;
      3'd1, 3'd3: r = 5'd7;
      default:    r = NoReg;
    endcase
    return r;
  endfunction

endpackage

@@ src/x86ea_req_if.sv @@
interface x86ea_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  modrm_byte;
  logic [7:0]  sib_byte;
  logic [31:0] disp_raw;
  logic [1:0]  addr_size;
  logic        rex_x_bit;
  logic        rex_b_bit;
  logic        long_mode;
  logic [2:0]  seg_override;
  logic        add_seg_base;
  logic [3:0]  esp_pop_adjust;
  logic [63:0] disp_address;
  logic [2:0]  rip_extra;

  modport source (
    output valid, modrm_byte, sib_byte, disp_raw, addr_size, rex_x_bit, rex_b_bit,
           long_mode, seg_override, add_seg_base, esp_pop_adjust, disp_address,
           rip_extra,
    input  ready
  );

  modport sink (
    input  valid, modrm_byte, sib_byte, disp_raw, addr_size, rex_x_bit, rex_b_bit,
           long_mode, seg_override, add_seg_base, esp_pop_adjust, disp_address,
           rip_extra,
    output ready
  );
endinterface

@@ src/x86ea_rsp_if.sv @@
interface x86ea_rsp_if;
  logic               valid;
  logic               ready;
  logic [4:0]         base_reg;
  logic [4:0]         index_reg;
  logic [1:0]         scale_shift;
  logic signed [63:0] displacement;
  logic [2:0]         segment_used;
  logic               wrap_16;
  logic [2:0]         extra_bytes;

  modport source (
    output valid, base_reg, index_reg, scale_shift, displacement, segment_used,
           wrap_16, extra_bytes,
    input  ready
  );

  modport sink (
    input  valid, base_reg, index_reg, scale_shift, displacement, segment_used,
           wrap_16, extra_bytes,
    output ready
  );
endinterface

@@ src/x86_modrm_sib_address_decode_core.sv @@
// Channel   Direction   Handshake     Payload
// req_i     in          valid/ready   ModRM, SIB, displacement bytes, mode bits
// rsp_o     out         valid/ready   base, index, scale, displacement, segment
//
// One item per cycle sustained while rsp_o.ready is high; path: input register,
// then decode and the 64-bit displacement add, then result register.
// rst_ni clears both stage valid flags asynchronously; payload is not reset.
// A stalled result holds in the result register while the input register
// still takes one more transfer; req_i.ready drops only when both are full.
module x86_modrm_sib_address_decode_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  x86ea_req_if.sink         req_i,
  x86ea_rsp_if.source       rsp_o
);

  x86ea_pkg::req_t req_in;
  x86ea_pkg::req_t req_q;
  x86ea_pkg::rsp_t rsp_d;
  x86ea_pkg::rsp_t rsp_q;
  logic            mid_valid;
  logic            mid_ready;

  assign req_in.modrm_byte     = req_i.modrm_byte;
  assign req_in.sib_byte       = req_i.sib_byte;
  assign req_in.disp_raw       = req_i.disp_raw;
  assign req_in.addr_size      = req_i.addr_size;
  assign req_in.rex_x_bit      = req_i.rex_x_bit;
  assign req_in.rex_b_bit      = req_i.rex_b_bit;
  assign req_in.long_mode      = req_i.long_mode;
  assign req_in.seg_override   = req_i.seg_override;
  assign req_in.add_seg_base   = req_i.add_seg_base;
  assign req_in.esp_pop_adjust = req_i.esp_pop_adjust;
  assign req_in.disp_address   = req_i.disp_address;
  assign req_in.rip_extra      = req_i.rip_extra;

  x86ea_stage #(
    .data_t(x86ea_pkg::req_t)
  ) u_in_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(req_i.valid),
    .ready_o(req_i.ready),
    .data_i (req_in),
    .valid_o(mid_valid),
    .ready_i(mid_ready),
    .data_o (req_q)
  );

  x86ea_decode u_decode (
    .req_i(req_q),
    .rsp_o(rsp_d)
  );

  x86ea_stage #(
    .data_t(x86ea_pkg::rsp_t)
  ) u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(mid_valid),
    .ready_o(mid_ready),
    .data_i (rsp_d),
    .valid_o(rsp_o.valid),
    .ready_i(rsp_o.ready),
    .data_o (rsp_q)
  );

  assign rsp_o.base_reg     = rsp_q.base_reg;
  assign rsp_o.index_reg    = rsp_q.index_reg;
  assign rsp_o.scale_shift  = rsp_q.scale_shift;
  assign rsp_o.displacement = rsp_q.displacement;
  assign rsp_o.segment_used = rsp_q.segment_used;
  assign rsp_o.wrap_16      = rsp_q.wrap_16;
  assign rsp_o.extra_bytes  = rsp_q.extra_bytes;

endmodule

@@ src/x86ea_stage.sv @@
module x86ea_stage #(
  parameter type data_t = logic
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  data_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output data_t data_o
);

  logic  valid_q, valid_d;
  data_t data_q;

  // take a new transfer when empty or whenever the held one leaves in the same cycle
  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ src/x86ea_decode.sv @@
module x86ea_decode (
  input  x86ea_pkg::req_t req_i,
  output x86ea_pkg::rsp_t rsp_o
);

  logic [1:0]  mod_f;
  logic [2:0]  rm_f;
  logic        has_sib;
  logic [2:0]  base_lo;
  logic [3:0]  base_full;
  logic [3:0]  idx_full;
  logic [63:0] sext8_v;
  logic [63:0] sext32_v;
  logic [63:0] zext16_v;
  logic [63:0] disp_v;
  logic        rip_rel;
  logic        pop_adj;
  logic        ss_default;
  logic        has_ovr;
  logic [63:0] addend;
  x86ea_pkg::rsp_t r;

  assign mod_f     = req_i.modrm_byte[7:6];
  assign rm_f      = req_i.modrm_byte[2:0];
  assign has_sib   = (rm_f == x86ea_pkg::RmSib);
  assign base_lo   = has_sib ? req_i.sib_byte[2:0] : rm_f;
  assign base_full = {req_i.rex_b_bit, base_lo};
  assign idx_full  = {req_i.rex_x_bit, req_i.sib_byte[5:3]};
  assign sext8_v   = {{56{req_i.disp_raw[7]}}, req_i.disp_raw[7:0]};
  assign sext32_v  = {{32{req_i.disp_raw[31]}}, req_i.disp_raw};
  assign zext16_v  = {48'd0, req_i.disp_raw[15:0]};
  assign has_ovr   = (req_i.seg_override <= x86ea_pkg::SegLastOverride);

  always_comb begin
    r          = '0;
    r.base_reg = x86ea_pkg::NoReg;
    r.index_reg = x86ea_pkg::NoReg;
    disp_v     = '0;
    rip_rel    = 1'b0;
    pop_adj    = 1'b0;
    ss_default = 1'b0;

    if (req_i.addr_size != x86ea_pkg::AddrSize16) begin
      r.extra_bytes = {2'd0, has_sib};
      r.base_reg    = {1'b0, base_full};
      if (mod_f == x86ea_pkg::ModNoDisp) begin
        if (base_lo == x86ea_pkg::BaseDisp32) begin
          r.base_reg    = x86ea_pkg::NoReg;
          disp_v        = sext32_v;
          r.extra_bytes = {2'd0, has_sib} + 3'd4;
          rip_rel       = req_i.long_mode && !has_sib;
        end
      end else if (mod_f == x86ea_pkg::ModDisp8) begin
        disp_v        = sext8_v;
        r.extra_bytes = {2'd0, has_sib} + 3'd1;
      end else begin
        disp_v        = sext32_v;
        r.extra_bytes = {2'd0, has_sib} + 3'd4;
      end
      pop_adj = (r.base_reg == x86ea_pkg::RegEsp);
      if (has_sib && idx_full != x86ea_pkg::IndexNone) begin
        r.index_reg   = {1'b0, idx_full};
        r.scale_shift = req_i.sib_byte[7:6];
      end
      ss_default = (r.base_reg == x86ea_pkg::RegEsp) || (r.base_reg == x86ea_pkg::RegEbp);
    end else if (mod_f == x86ea_pkg::ModNoDisp && rm_f == x86ea_pkg::RmDirect16) begin
      disp_v        = zext16_v;
      r.extra_bytes = 3'd2;
    end else begin
      if (mod_f == x86ea_pkg::ModDisp8) begin
        disp_v        = sext8_v;
        r.extra_bytes = 3'd1;
      end else if (mod_f != x86ea_pkg::ModNoDisp) begin
        disp_v        = zext16_v;
        r.extra_bytes = 3'd2;
      end
      r.base_reg  = x86ea_pkg::base16(rm_f);
      r.index_reg = x86ea_pkg::index16(rm_f);
      r.wrap_16   = 1'b1;
      ss_default  = (rm_f == 3'd2) || (rm_f == 3'd3) || (rm_f == 3'd6);
    end

    // RIP-relative and POP adjustment never apply together
    if (rip_rel) begin
      addend = req_i.disp_address + 64'd4 + {61'd0, req_i.rip_extra};
    end else if (pop_adj) begin
      addend = {60'd0, req_i.esp_pop_adjust};
    end else begin
      addend = '0;
    end
    r.displacement = disp_v + addend;

    if (has_ovr) begin
      r.segment_used = req_i.seg_override;
    end else if (req_i.add_seg_base) begin
      r.segment_used = ss_default ? x86ea_pkg::SegSs : x86ea_pkg::SegDs;
    end else begin
      r.segment_used = x86ea_pkg::SegNone;
    end
  end

  assign rsp_o = r;

endmodule

@@ src/x86ea_checker.sv @@
`include "x86_modrm_sib_address_decode_core_assert.svh"

module x86ea_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [4:0]  base_reg_i,
  input logic [4:0]  index_reg_i,
  input logic [1:0]  scale_shift_i,
  input logic [63:0] displacement_i,
  input logic [2:0]  segment_used_i,
  input logic        wrap_16_i,
  input logic [2:0]  extra_bytes_i
);

  `X86EA_ASSERT_HOLD(a_rsp_hold, clk_i, rst_ni, rsp_valid_i, rsp_ready_i, {base_reg_i, index_reg_i, scale_shift_i, displacement_i, segment_used_i, wrap_16_i, extra_bytes_i}, "result changed while stalled")
  `X86EA_ASSERT(a_scale_needs_index, clk_i, rst_ni, (rsp_valid_i && scale_shift_i != 2'd0) |-> (index_reg_i != x86ea_pkg::NoReg), "scale without index")
  `X86EA_ASSERT(a_wrap_form, clk_i, rst_ni, (rsp_valid_i && wrap_16_i) |-> (extra_bytes_i <= 3'd2 && base_reg_i != x86ea_pkg::NoReg && scale_shift_i == 2'd0), "bad 16-bit wrap result")
  `X86EA_ASSERT(a_reg_range, clk_i, rst_ni, rsp_valid_i |-> (base_reg_i <= x86ea_pkg::NoReg && index_reg_i <= x86ea_pkg::NoReg && extra_bytes_i <= 3'd5 && segment_used_i <= x86ea_pkg::SegNone), "result field out of range")

endmodule

bind x86_modrm_sib_address_decode_core x86ea_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .base_reg_i    (rsp_o.base_reg),
  .index_reg_i   (rsp_o.index_reg),
  .scale_shift_i (rsp_o.scale_shift),
  .displacement_i(rsp_o.displacement),
  .segment_used_i(rsp_o.segment_used),
  .wrap_16_i     (rsp_o.wrap_16),
  .extra_bytes_i (rsp_o.extra_bytes)
);
